/* src/lbm_d2q9_velocity_norm_defines.svh */
// assertion helpers shared by the velocity norm block
`ifndef LBM_D2Q9_VELOCITY_NORM_DEFINES_SVH
`define LBM_D2Q9_VELOCITY_NORM_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define LBMV_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define LBMV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lbmv_pkg.sv */
package lbmv_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int F_W = 16;
	localparam int RHO_W = 20;
	localparam int MOM_W = 18;
	localparam int SPEED_W = 17;
	localparam logic [SPEED_W-1:0] OBST_SPEED = 17'h1F99A;
	localparam logic [15:0] SPEED_MAX = 16'hFFFF;

	typedef struct packed {
		logic valid;
		logic obst;
		logic zero;
	} ctl_t;
endpackage

/* src/lbm_d2q9_velocity_norm.sv */
// throughput: one cell per cycle; the whole chain advances together and halts
//   only while a finished result waits on m_tready
// path from input request to result: the front register, the FRAC_BITS+1
//   divider cells, the square and sum registers, the FRAC_BITS+1 square-root
//   cells and the output register
// reset: arst_n low clears all valid bits at once; payload registers are not reset
module lbm_d2q9_velocity_norm #(
	parameter int FRAC_BITS = lbmv_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// f_rest, f_east, f_north, f_west, f_south, f_northeast, f_northwest,
	// f_southwest, f_southeast (16 bits each, lowest first)
	input  logic [143:0] s_tdata,
	// is_obstacle
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// speed_norm [16:0], zero_density [17], zeros above
	output logic [23:0]  m_tdata
);
	import lbmv_pkg::*;

	localparam int NC = FRAC_BITS + 1;     // cells per chain
	localparam int SW = 2*FRAC_BITS + 2;   // width of the sum of squares
	localparam int RW = FRAC_BITS + 3;     // square-root remainder width
	localparam int SH = FRAC_BITS - 15;    // shift to q1.15

	// global advance: the chain moves unless the output holds an untaken result
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// front: density, momentum magnitudes, special-case flags
	ctl_t             d_ctl  [0:NC];
	logic [RHO_W-1:0] d_rho  [0:NC];
	logic [RHO_W-1:0] d_rx   [0:NC];
	logic [RHO_W-1:0] d_ry   [0:NC];
	logic [FRAC_BITS:0] d_qx [0:NC];
	logic [FRAC_BITS:0] d_qy [0:NC];
	logic [1:0]       lsb_s1;

	lbmv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (s_tvalid),
		.f_all       (s_tdata),
		.is_obstacle (s_tuser),
		.ctl_q       (d_ctl[0]),
		.rho_q       (d_rho[0]),
		.rx_q        (d_rx[0]),
		.ry_q        (d_ry[0]),
		.lsb_q       (lsb_s1)
	);
	assign d_qx[0] = '0;
	assign d_qy[0] = '0;

	// divider chain: one quotient bit of ux and uy per cell
	for (genvar k = 0; k < NC; k++) begin : g_div
		logic [1:0] bits;
		assign bits = (k == 0) ? lsb_s1 : 2'b00;
		lbmv_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (d_ctl[k]),
			.rho_in (d_rho[k]),
			.rx_in  (d_rx[k]),
			.ry_in  (d_ry[k]),
			.bit_in (bits),
			.qx_in  (d_qx[k]),
			.qy_in  (d_qy[k]),
			.ctl_q  (d_ctl[k+1]),
			.rho_q  (d_rho[k+1]),
			.rx_q   (d_rx[k+1]),
			.ry_q   (d_ry[k+1]),
			.qx_q   (d_qx[k+1]),
			.qy_q   (d_qy[k+1])
		);
	end

	// squares, then their sum
	ctl_t          sq_ctl_s1, sum_ctl_s2;
	logic [SW-1:0] sqx_s1, sqy_s1, sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_ctl_s1  <= '0;
			sum_ctl_s2 <= '0;
		end else if (en) begin
			sq_ctl_s1  <= d_ctl[NC];
			sum_ctl_s2 <= sq_ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= SW'(d_qx[NC]) * SW'(d_qx[NC]);
			sqy_s1 <= SW'(d_qy[NC]) * SW'(d_qy[NC]);
			sum_s2 <= sqx_s1 + sqy_s1;
		end
	end

	// square-root chain: one root bit per cell, two radicand bits in
	ctl_t               r_ctl  [0:NC];
	logic [SW-1:0]      r_s    [0:NC];
	logic [RW-1:0]      r_rem  [0:NC];
	logic [FRAC_BITS:0] r_root [0:NC];

	assign r_ctl[0]  = sum_ctl_s2;
	assign r_s[0]    = sum_s2;
	assign r_rem[0]  = '0;
	assign r_root[0] = '0;

	for (genvar k = 0; k < NC; k++) begin : g_sqrt
		lbmv_sqrt_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (r_ctl[k]),
			.s_in    (r_s[k]),
			.rem_in  (r_rem[k]),
			.root_in (r_root[k]),
			.ctl_q   (r_ctl[k+1]),
			.s_q     (r_s[k+1]),
			.rem_q   (r_rem[k+1]),
			.root_q  (r_root[k+1])
		);
	end

	// scale to q1.15 with round half up
	logic [SPEED_W-1:0] q_scaled;
	if (SH > 0) begin : g_rnd
		logic [FRAC_BITS+1:0] n_rnd;
		assign n_rnd    = {1'b0, r_root[NC]} + ((FRAC_BITS+2)'(1) << (SH-1));
		assign q_scaled = SPEED_W'(n_rnd[FRAC_BITS+1:SH]);
	end else if (SH < 0) begin : g_shl
		logic [15:0] n_shl;
		assign n_shl    = {r_root[NC], {(-SH){1'b0}}};
		assign q_scaled = SPEED_W'(n_shl);
	end else begin : g_same
		assign q_scaled = SPEED_W'(r_root[NC]);
	end

	logic [SPEED_W-1:0] q_sat;
	assign q_sat = (q_scaled > SPEED_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX) : q_scaled;

	// output register; obstacle wins over zero density
	logic               out_valid_q;
	logic [SPEED_W-1:0] speed_q;
	logic               zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= r_ctl[NC].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (r_ctl[NC].obst) begin
				speed_q <= OBST_SPEED;
				zero_q  <= 1'b0;
			end else if (r_ctl[NC].zero) begin
				speed_q <= '0;
				zero_q  <= 1'b1;
			end else begin
				speed_q <= q_sat;
				zero_q  <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, zero_q, speed_q};

`include "lbm_d2q9_velocity_norm_defines.svh"

	// a flagged zero density always carries a zero speed
	`LBMV_ASSERT_SAME(a_zero_speed, m_tvalid && m_tdata[17], m_tdata[16:0] == '0, "zero density with nonzero speed")
	// the only negative speed is the obstacle sentinel
	`LBMV_ASSERT_SAME(a_neg_sentinel, m_tvalid && m_tdata[16], m_tdata[16:0] == OBST_SPEED, "negative speed is not the obstacle mark")
	// a held chain keeps its last divider and root valid bits
	`LBMV_ASSERT_NEXT(a_stall_hold, !en, $stable(d_ctl[NC].valid) && $stable(r_ctl[NC].valid), "chain moved while stalled")
endmodule

/* src/lbmv_front.sv */
module lbmv_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [9*lbmv_pkg::F_W-1:0]   f_all,
	input  logic                         is_obstacle,
	output lbmv_pkg::ctl_t               ctl_q,
	output logic [lbmv_pkg::RHO_W-1:0]   rho_q,
	output logic [lbmv_pkg::RHO_W-1:0]   rx_q,
	output logic [lbmv_pkg::RHO_W-1:0]   ry_q,
	output logic [1:0]                   lsb_q
);
	import lbmv_pkg::*;

	logic [F_W-1:0]   f [0:8];
	logic [RHO_W-1:0] rho;
	logic [MOM_W-1:0] px, nx, py, ny, mx, my;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			f[i] = f_all[i*F_W +: F_W];
		end
		rho = RHO_W'(f[0]) + RHO_W'(f[1]) + RHO_W'(f[2]) + RHO_W'(f[3]) + RHO_W'(f[4])
			+ RHO_W'(f[5]) + RHO_W'(f[6]) + RHO_W'(f[7]) + RHO_W'(f[8]);
		// order: rest, e, n, w, s, ne, nw, sw, se
		px = MOM_W'(f[1]) + MOM_W'(f[5]) + MOM_W'(f[8]);
		nx = MOM_W'(f[3]) + MOM_W'(f[6]) + MOM_W'(f[7]);
		py = MOM_W'(f[2]) + MOM_W'(f[5]) + MOM_W'(f[6]);
		ny = MOM_W'(f[4]) + MOM_W'(f[7]) + MOM_W'(f[8]);
		mx = (px >= nx) ? px - nx : nx - px;
		my = (py >= ny) ? py - ny : ny - py;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q.valid <= in_valid;
			ctl_q.obst  <= is_obstacle;
			ctl_q.zero  <= (rho == '0);
		end
	end

	// top quotient bits are always zero since |m| <= rho
	always_ff @(posedge clk) begin
		if (en) begin
			rho_q <= rho;
			rx_q  <= RHO_W'(mx[MOM_W-1:1]);
			ry_q  <= RHO_W'(my[MOM_W-1:1]);
			lsb_q <= {my[0], mx[0]};
		end
	end
endmodule

/* src/lbmv_div_cell.sv */
module lbmv_div_cell #(
	parameter int FRAC_BITS = lbmv_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  lbmv_pkg::ctl_t             ctl_in,
	input  logic [lbmv_pkg::RHO_W-1:0] rho_in,
	input  logic [lbmv_pkg::RHO_W-1:0] rx_in,
	input  logic [lbmv_pkg::RHO_W-1:0] ry_in,
	input  logic [1:0]                 bit_in,
	input  logic [FRAC_BITS:0]         qx_in,
	input  logic [FRAC_BITS:0]         qy_in,
	output lbmv_pkg::ctl_t             ctl_q,
	output logic [lbmv_pkg::RHO_W-1:0] rho_q,
	output logic [lbmv_pkg::RHO_W-1:0] rx_q,
	output logic [lbmv_pkg::RHO_W-1:0] ry_q,
	output logic [FRAC_BITS:0]         qx_q,
	output logic [FRAC_BITS:0]         qy_q
);
	import lbmv_pkg::*;

	logic [RHO_W:0] tx, ty, dx, dy;
	logic           gx, gy;

	always_comb begin
		tx = {rx_in, bit_in[0]};
		ty = {ry_in, bit_in[1]};
		dx = tx - {1'b0, rho_in};
		dy = ty - {1'b0, rho_in};
		gx = (tx >= {1'b0, rho_in});
		gy = (ty >= {1'b0, rho_in});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rho_q <= rho_in;
			rx_q  <= gx ? dx[RHO_W-1:0] : tx[RHO_W-1:0];
			ry_q  <= gy ? dy[RHO_W-1:0] : ty[RHO_W-1:0];
			qx_q  <= {qx_in[FRAC_BITS-1:0], gx};
			qy_q  <= {qy_in[FRAC_BITS-1:0], gy};
		end
	end
endmodule

/* src/lbmv_sqrt_cell.sv */
module lbmv_sqrt_cell #(
	parameter int FRAC_BITS = lbmv_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  lbmv_pkg::ctl_t           ctl_in,
	input  logic [2*FRAC_BITS+1:0]   s_in,
	input  logic [FRAC_BITS+2:0]     rem_in,
	input  logic [FRAC_BITS:0]       root_in,
	output lbmv_pkg::ctl_t           ctl_q,
	output logic [2*FRAC_BITS+1:0]   s_q,
	output logic [FRAC_BITS+2:0]     rem_q,
	output logic [FRAC_BITS:0]       root_q
);
	import lbmv_pkg::*;

	localparam int SW = 2*FRAC_BITS + 2;
	localparam int RW = FRAC_BITS + 3;

	logic [RW-1:0] rem_sh, trial, diff;
	logic          take;

	always_comb begin
		rem_sh = {rem_in[RW-3:0], s_in[SW-1:SW-2]};
		trial  = {root_in, 2'b01};
		diff   = rem_sh - trial;
		take   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_q    <= {s_in[SW-3:0], 2'b00};
			rem_q  <= take ? diff : rem_sh;
			root_q <= {root_in[FRAC_BITS-1:0], take};
		end
	end
endmodule
